// ===== rtl/core/longest_nondecreasing_subsequence_top_defines.svh =====
// Assertion macros used by the checker file of the subsequence tracker.
`ifndef LONGEST_NONDECREASING_SUBSEQUENCE_TOP_DEFINES_SVH
`define LONGEST_NONDECREASING_SUBSEQUENCE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LNDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LNDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lnds_pkg.sv =====
// Shared constants and the item record that travels down the cell chain.
package lnds_pkg;

  localparam int DEPTH       = 1024;
  localparam int VALUE_W     = 32;
  localparam int LEN_W       = $clog2(DEPTH + 1);
  localparam int IN_TDATA_W  = ((VALUE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((LEN_W + 7) / 8) * 8;

  typedef struct packed {
    logic                      vld;
    logic                      first;
    logic                      placed;
    logic signed [VALUE_W-1:0] key;
    logic        [LEN_W-1:0]   len;
  } item_t;

endpackage

// ===== rtl/core/lnds_cell.sv =====
// One tail slot of the patience-sorting chain with its pipeline register.
module lnds_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  lnds_pkg::item_t item_i,
  output lnds_pkg::item_t item_o
);
  import lnds_pkg::*;

  logic signed [VALUE_W-1:0] tail_q;
  logic                      occ_q;
  logic                      occ_d;
  logic                      live;
  logic                      hit;
  item_t                     item_d;
  item_t                     item_q;

  always_comb begin
    // a sequence start empties every slot it passes
    live   = item_i.first ? 1'b0 : occ_q;
    hit    = item_i.vld & ~item_i.placed & (~live | (tail_q > item_i.key));
    occ_d  = item_i.vld ? (live | hit) : occ_q;
    item_d = item_i;
    item_d.placed = item_i.placed | hit;
    item_d.len    = item_i.len + LEN_W'(occ_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i && hit) begin
      tail_q <= item_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      item_q <= '0;
    end else if (en_i) begin
      occ_q  <= occ_d;
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// ===== rtl/core/longest_nondecreasing_subsequence_top.sv =====
// Top level: longest non-decreasing subsequence tracker built as a chain of tail cells.
// Each input item enters cell 0 and moves one cell per cycle down a chain of DEPTH (1024)
// cells; cell i holds the smallest value that ends a non-decreasing run of length i+1.
// The first cell holding a value strictly greater than the item takes the item's value,
// or the first empty cell takes it as an append. A new item may enter every cycle, and
// its result passes the DEPTH cell registers and then the output register. The whole
// chain holds while a result waits on m_axis_tready. s_axis_tuser set starts a new
// sequence. m_axis_tdata carries the running length and m_axis_tuser reports that an
// append was dropped because all cells were in use.
module longest_nondecreasing_subsequence_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lnds_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [31:0] value (signed)
  input  logic                                s_axis_tuser,   // [0] first
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lnds_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [10:0] length, rest zero
  output logic                                m_axis_tuser    // [0] overflow
);
  import lnds_pkg::*;

  item_t            chain [DEPTH+1];
  item_t            last_item;
  logic             adv;
  logic             out_vld_q;
  logic             ovf_q;
  logic [LEN_W-1:0] len_q;

  assign adv = ~out_vld_q | m_axis_tready;

  always_comb begin
    chain[0]        = '0;
    chain[0].vld    = s_axis_tvalid;
    chain[0].first  = s_axis_tuser;
    chain[0].key    = s_axis_tdata[VALUE_W-1:0];
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lnds_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .item_i (chain[i]),
      .item_o (chain[i+1])
    );
  end

  assign last_item = chain[DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      ovf_q     <= 1'b0;
    end else if (adv) begin
      out_vld_q <= last_item.vld;
      // unplaced after the last cell: every slot in use, drop the append
      if (last_item.vld) begin
        ovf_q <= (~last_item.first & ovf_q) | ~last_item.placed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_item.vld) begin
      len_q <= last_item.len;
    end
  end

  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'(len_q);
  assign m_axis_tuser  = ovf_q;

endmodule

// ===== rtl/core/lnds_checker.sv =====
// Port-level checks for the subsequence tracker, bound to the top level.
`include "longest_nondecreasing_subsequence_top_defines.svh"

module lnds_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [lnds_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] value (signed)
  input logic                             s_axis_tuser,   // [0] first
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lnds_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [10:0] length, rest zero
  input logic                             m_axis_tuser    // [0] overflow
);
  import lnds_pkg::*;

  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(DEPTH);

  logic [LEN_W-1:0]       out_len;
  logic                   out_stall;
  logic                   in_stall;
  logic [OUT_TDATA_W:0]   out_word;
  logic [IN_TDATA_W:0]    in_word;

  assign out_len   = m_axis_tdata[LEN_W-1:0];
  assign out_stall = m_axis_tvalid & ~m_axis_tready;
  assign in_stall  = s_axis_tvalid & ~s_axis_tready;
  assign out_word  = {m_axis_tuser, m_axis_tdata};
  assign in_word   = {s_axis_tuser, s_axis_tdata};

  `LNDS_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "result moved")
  `LNDS_ASSERT_NOW(a_ready_rule, 1'b1, s_axis_tready == !out_stall, "bad input ready")
  `LNDS_ASSERT_NOW(a_len_range, m_axis_tvalid, out_len != '0 && out_len <= FULL_LEN, "bad length")
  `LNDS_ASSERT_NOW(a_ovf_full, m_axis_tvalid && m_axis_tuser, out_len == FULL_LEN, "early overflow")
  `LNDS_ASSERT_NEXT(a_in_hold, in_stall, s_axis_tvalid && $stable(in_word), "input item moved")

endmodule

bind longest_nondecreasing_subsequence_top lnds_checker u_lnds_checker (.*);
